FILE: src/assert_macros.svh
// assert_macros.svh
// Assertion shorthands for the battery gauge RTL; no dependencies.
// Every macro samples on clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_CLK(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Condition must never be seen at a clock edge out of reset.
`define ASSERT_NEVER(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

FILE: src/bmag_pkg.sv
// bmag_pkg.sv
// Constants, widths and controller/datapath interface types of the battery gauge.
// No dependencies.
`timescale 1ns / 1ps

package bmag_pkg;

   // window size and field widths
   localparam int WINDOW_DEPTH = 100;
   localparam int RAW_W        = 13;
   localparam int MV_W         = 13;
   localparam int PCT_W        = 7;
   localparam int MV_MAX       = 4800;
   localparam int SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int COUNT_W      = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W        = $clog2(MV_MAX * WINDOW_DEPTH + 1);

   // millivolt scaling: raw * 800 / 8191, then * 6 (8191 = 2^13 - 1)
   localparam int SCALE_MUL    = 800;
   localparam int SCALE_MUL_W  = 10;
   localparam int SCALE_SHIFT  = 13;
   localparam int SCALE_DEN    = (1 << SCALE_SHIFT) - 1;
   localparam int PROD_W       = RAW_W + SCALE_MUL_W;
   localparam int Q0_W         = PROD_W - SCALE_SHIFT;
   localparam int MV_STEP      = 6;

   // percentage
   localparam int PCT_FULL     = 99;
   localparam int PNUM_W       = MV_W + PCT_W;

   // shared divider
   localparam int DIVD_W       = (SUM_W > PNUM_W) ? SUM_W : PNUM_W;
   localparam int DIVS_W       = (MV_W > COUNT_W) ? MV_W : COUNT_W;
   localparam int DCNT_W       = $clog2(DIVD_W);

   // stream and register port widths
   localparam int REQ_TDATA_W  = ((RAW_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W  = ((MV_W + PCT_W + 7) / 8) * 8;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   // register map
   localparam logic REG_EMPTY_LEVEL = 1'b0;
   localparam logic REG_FULL_LEVEL  = 1'b1;
   localparam logic [MV_W-1:0] EMPTY_LEVEL_RESET = MV_W'(3300);
   localparam logic [MV_W-1:0] FULL_LEVEL_RESET  = MV_W'(4200);

   // input item kinds
   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_CLEAR  = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic capture;        // latch the incoming sample
      logic clear;          // empty the window
      logic scale;          // raw * 800, read oldest slot
      logic convert;        // finish division by 8191, times 6
      logic update;         // sum, slot, fill and window write
      logic div_avg_start;  // sum / fill
      logic avg_take;
      logic pct_prep;       // clamp check and percent numerator
      logic div_pct_start;  // numerator / level span
      logic pct_take;
      logic emit;           // load output register
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_done;
      logic pct_direct;     // clamped, no division needed
      logic out_free;
   } dp_status_type;

endpackage

FILE: src/bmag_div.sv
// bmag_div.sv
// Radix-2 restoring divider shared by the average and percentage steps.
// Depends on bmag_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmag_div import bmag_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [DIVS_W-1:0] divisor,
   output logic              done,
   output logic [DIVD_W-1:0] quotient
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [DIVS_W-1:0] rem_ff, rem_in;
   logic [DIVS_W-1:0] dvs_ff, dvs_in;
   logic [DIVS_W:0]   trial;
   logic              fits;

   // one quotient bit per cycle, dividend shifted out of the quotient register
   always_comb begin
      trial   = {rem_ff, quo_ff[DIVD_W-1]};
      fits    = (trial >= {1'b0, dvs_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? DIVS_W'(trial - {1'b0, dvs_ff}) : trial[DIVS_W-1:0];
         quo_in = {quo_ff[DIVD_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DCNT_W'(DIVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   `ASSERT_NEVER(a_div_restart, start && busy_ff, "divider started while busy")
   `ASSERT_NEVER(a_div_done_busy, done_ff && busy_ff, "divider done while still busy")

endmodule

FILE: src/bmag_dp.sv
// bmag_dp.sv
// Datapath: sample scaling, window memory, running sum, average and percentage.
// Depends on bmag_pkg, bmag_div and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmag_dp import bmag_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  dp_cmd_type             cmd,
   output dp_status_type          status,
   input  logic [RAW_W-1:0]       raw_sample,
   input  logic [MV_W-1:0]        empty_level,
   input  logic [MV_W-1:0]        full_level,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic [MV_W-1:0]    window_mem [WINDOW_DEPTH];

   logic [RAW_W-1:0]   raw_ff;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [MV_W-1:0]    old_ff;
   logic [MV_W-1:0]    mv_ff, mv_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [COUNT_W-1:0] fill_ff, fill_in;
   logic [MV_W-1:0]    avg_ff;
   logic [PNUM_W-1:0]  numer_ff, numer_in;
   logic [PCT_W-1:0]   pct_ff;
   logic               out_valid_ff, out_valid_in;
   logic [MV_W-1:0]    out_avg_ff;
   logic [PCT_W-1:0]   out_pct_ff;

   logic [Q0_W-1:0]          q0;
   logic [SCALE_SHIFT:0]     rsum;
   logic [Q0_W-1:0]          q;
   logic                     full_win;
   logic                     at_empty;
   logic                     at_full;
   logic [MV_W-1:0]          span;
   logic                     div_start;
   logic [DIVD_W-1:0]        div_dividend;
   logic [DIVS_W-1:0]        div_divisor;
   logic                     div_done;
   logic [DIVD_W-1:0]        div_quotient;

   // raw * 800; x / 8191 is (x >> 13), plus one if x[12:0] + (x >> 13) >= 8191
   always_comb begin
      prod_in = PROD_W'(raw_ff) * PROD_W'(SCALE_MUL);
      q0      = prod_ff[PROD_W-1 -: Q0_W];
      rsum    = {1'b0, prod_ff[SCALE_SHIFT-1:0]} + (SCALE_SHIFT + 1)'(q0);
      q       = q0 + Q0_W'(rsum >= (SCALE_SHIFT + 1)'(SCALE_DEN));
      mv_in   = MV_W'(q) * MV_W'(MV_STEP);
   end

   // window bookkeeping
   always_comb begin
      full_win = (fill_ff == COUNT_W'(WINDOW_DEPTH));
      sum_in   = sum_ff - (full_win ? SUM_W'(old_ff) : '0) + SUM_W'(mv_ff);
      slot_in  = (slot_ff == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
      fill_in  = full_win ? fill_ff : fill_ff + 1'b1;
   end

   // percentage clamp and numerator
   always_comb begin
      at_empty = (avg_ff <= empty_level);
      at_full  = (avg_ff >= full_level);
      span     = full_level - empty_level;
      numer_in = PNUM_W'(avg_ff - empty_level) * PNUM_W'(PCT_FULL);
   end

   // divider operand select
   always_comb begin
      div_start    = cmd.div_avg_start | cmd.div_pct_start;
      div_dividend = cmd.div_pct_start ? DIVD_W'(numer_ff) : DIVD_W'(sum_ff);
      div_divisor  = cmd.div_pct_start ? DIVS_W'(span) : DIVS_W'(fill_ff);
   end

   bmag_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // output register: a new item may load it in the cycle the old one leaves
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // window memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         old_ff <= window_mem[slot_ff];
      end
      if (cmd.update) begin
         window_mem[slot_ff] <= mv_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         slot_ff      <= '0;
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (cmd.clear) begin
            sum_ff  <= '0;
            slot_ff <= '0;
            fill_ff <= '0;
         end else if (cmd.update) begin
            sum_ff  <= sum_in;
            slot_ff <= slot_in;
            fill_ff <= fill_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         raw_ff <= raw_sample;
      end
      if (cmd.scale) begin
         prod_ff <= prod_in;
      end
      if (cmd.convert) begin
         mv_ff <= mv_in;
      end
      if (cmd.avg_take) begin
         avg_ff <= div_quotient[MV_W-1:0];
      end
      if (cmd.pct_prep) begin
         numer_ff <= numer_in;
         pct_ff   <= at_empty ? '0 : PCT_W'(PCT_FULL);
      end else if (cmd.pct_take) begin
         pct_ff <= div_quotient[PCT_W-1:0];
      end
      if (cmd.emit) begin
         out_avg_ff <= avg_ff;
         out_pct_ff <= pct_ff;
      end
   end

   always_comb begin
      status.div_done   = div_done;
      status.pct_direct = at_empty | at_full;
      status.out_free   = ~out_valid_ff | rsp_tready;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({out_pct_ff, out_avg_ff});

   `ASSERT_CLK(a_fill_bound, fill_ff <= COUNT_W'(WINDOW_DEPTH), "fill count beyond window")
   `ASSERT_CLK(a_sum_bound, 32'(sum_ff) <= 32'(MV_MAX) * 32'(fill_ff),
      "running sum exceeds full-scale times fill count")

endmodule

FILE: src/bmag_ctrl.sv
// bmag_ctrl.sv
// Controller: sequences one item through the datapath and the shared divider.
// Depends on bmag_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmag_ctrl import bmag_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tuser,
   output logic          req_tready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_SCALE     = 4'd1;
   localparam logic [3:0] ST_CONVERT   = 4'd2;
   localparam logic [3:0] ST_UPDATE    = 4'd3;
   localparam logic [3:0] ST_AVG_START = 4'd4;
   localparam logic [3:0] ST_AVG_WAIT  = 4'd5;
   localparam logic [3:0] ST_PCT_PREP  = 4'd6;
   localparam logic [3:0] ST_PCT_START = 4'd7;
   localparam logic [3:0] ST_PCT_WAIT  = 4'd8;
   localparam logic [3:0] ST_EMIT      = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == MODE_CLEAR) begin
                  cmd.clear = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  state_in    = ST_SCALE;
               end
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_CONVERT;
         end
         ST_CONVERT: begin
            cmd.convert = 1'b1;
            state_in    = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_AVG_START;
         end
         ST_AVG_START: begin
            cmd.div_avg_start = 1'b1;
            state_in          = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            if (status.div_done) begin
               cmd.avg_take = 1'b1;
               state_in     = ST_PCT_PREP;
            end
         end
         ST_PCT_PREP: begin
            cmd.pct_prep = 1'b1;
            state_in     = status.pct_direct ? ST_EMIT : ST_PCT_START;
         end
         ST_PCT_START: begin
            cmd.div_pct_start = 1'b1;
            state_in          = ST_PCT_WAIT;
         end
         ST_PCT_WAIT: begin
            if (status.div_done) begin
               cmd.pct_take = 1'b1;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_CLK(a_emit_free, cmd.emit |-> status.out_free, "result loaded over a waiting one")
   `ASSERT_CLK(a_clear_idle, (accept && req_tuser == MODE_CLEAR) |=> state_ff == ST_IDLE,
      "clear item left the controller busy")

endmodule

FILE: src/battery_moving_average_gauge_unit.sv
// Battery moving-average gauge. Each sample item (tuser = 0) carries a 13-bit
// converter reading that is scaled to millivolts as (raw * 800 / 8191) * 6 and
// entered into a 100-deep circular window; the result item gives the window
// average and a 0..99 charge percentage, linear between the empty and full
// levels (CSR 0x0 and 0x4) and clamped at both ends. A clear item (tuser = 1)
// empties the window and gives no result. A sample makes two 20-step passes
// through the shared radix-2 divider, the second skipped when the percentage
// is clamped. One item is worked on at a time; a finished result waits in an
// output register while the next item is taken. Levels must be written only
// while the block is idle; the block itself does not enforce this.
//
// battery_moving_average_gauge_unit.sv: top level with the level registers.
// Depends on bmag_pkg, bmag_ctrl and bmag_dp.
`timescale 1ns / 1ps

module battery_moving_average_gauge_unit import bmag_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // input items
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [12:0] raw_sample
   input  logic                   req_tuser,   // [0] mode
   // result items
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [12:0] average_mv, [19:13] charge_percent
   // register port
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   logic [MV_W-1:0] empty_level_ff;
   logic [MV_W-1:0] full_level_ff;
   logic            csr_write;
   dp_cmd_type      cmd;
   dp_status_type   status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // level registers, selected by the word address bit
   always_ff @(posedge clock) begin
      if (reset) begin
         empty_level_ff <= EMPTY_LEVEL_RESET;
         full_level_ff  <= FULL_LEVEL_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_EMPTY_LEVEL: empty_level_ff <= csr_pwdata[MV_W-1:0];
            REG_FULL_LEVEL:  full_level_ff  <= csr_pwdata[MV_W-1:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (csr_paddr[2])
         REG_EMPTY_LEVEL: csr_prdata = CSR_DATA_W'(empty_level_ff);
         REG_FULL_LEVEL:  csr_prdata = CSR_DATA_W'(full_level_ff);
         default:         csr_prdata = '0;
      endcase
   end

   bmag_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   bmag_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .raw_sample  (req_tdata[RAW_W-1:0]),
      .empty_level (empty_level_ff),
      .full_level  (full_level_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule
